>>> rtl/core/moe_rc_pkg.sv
// Package for the expert route compactor: item structs, command, kind and
// register codes, and fixed field widths shared by all files of the block.
// No dependencies.
package moe_rc_pkg;

  localparam int MAX_TOPK = 8;
  localparam int ID_W     = 8;
  localparam int EXP_W    = 6;
  localparam int CNT_W    = 13;
  localparam int SLOT_W   = 12;
  localparam int ROUTE_W  = 15;
  localparam int MULT_W   = 4;
  localparam int TOPK_W   = 4;
  localparam int NE_W     = 7;
  localparam int LANE_W   = 3;

  localparam logic [CNT_W-1:0]  COUNT_MAX = 13'd8191;
  localparam logic [SLOT_W-1:0] SLOT_MAX  = 12'd4095;

  localparam logic [1:0] CMD_ROUTE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] KIND_ROUTE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] REG_TOP_K        = 2'd0;
  localparam logic [1:0] REG_NUM_EXPERTS  = 2'd1;
  localparam logic [1:0] REG_ROW_CAPACITY = 2'd2;

  typedef logic [MAX_TOPK-1:0][ID_W-1:0]   id_vec_t;
  typedef logic [MAX_TOPK-1:0][MULT_W-1:0] mult_vec_t;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [ID_W-1:0] expert_id_0;
    logic [ID_W-1:0] expert_id_1;
    logic [ID_W-1:0] expert_id_2;
    logic [ID_W-1:0] expert_id_3;
    logic [ID_W-1:0] expert_id_4;
    logic [ID_W-1:0] expert_id_5;
    logic [ID_W-1:0] expert_id_6;
    logic [ID_W-1:0] expert_id_7;
    logic [EXP_W-1:0] query_expert;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [EXP_W-1:0]   expert;
    logic [SLOT_W-1:0]  slot;
    logic [ROUTE_W-1:0] route_index;
    logic [MULT_W-1:0]  multiplicity;
    logic [CNT_W-1:0]   count;
    logic               overflow;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic              first;
    logic [MULT_W-1:0] mult;
  } lane_res_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [MAX_TOPK-1:0] mask;
    id_vec_t             ids;
    mult_vec_t           mult;
    logic [ROUTE_W-1:0]  base;
    logic                tok_ovf;
    logic [EXP_W-1:0]    query;
  } tok_load_t;

endpackage

>>> rtl/core/moe_rc_lane.sv
// One lane of the token front end: checks one position of the token for a
// valid first appearance and counts the positions that chose the same expert.
// Depends on moe_rc_pkg.
module moe_rc_lane (
  input  moe_rc_pkg::id_vec_t                   ids,
  input  logic [moe_rc_pkg::LANE_W-1:0]         own_pos,
  input  logic [moe_rc_pkg::TOPK_W-1:0]         k_eff,
  input  logic [8:0]                            ne_eff,
  output moe_rc_pkg::lane_res_t                 res
);

  logic [moe_rc_pkg::ID_W-1:0]     own_id;
  logic [moe_rc_pkg::MAX_TOPK-1:0] hit;
  logic [moe_rc_pkg::MAX_TOPK-1:0] earlier;
  logic [moe_rc_pkg::MULT_W-1:0]   sum;

  assign own_id = ids[own_pos];

  always_comb begin
    sum = '0;
    for (int q = 0; q < moe_rc_pkg::MAX_TOPK; q++) begin
      hit[q]     = (ids[q] == own_id) && (q < int'(k_eff));
      earlier[q] = hit[q] && (q < int'(own_pos));
      sum        = sum + moe_rc_pkg::MULT_W'(hit[q]);
    end
  end

  assign res.first = ({1'b0, own_pos} < k_eff) && ({1'b0, own_id} < ne_eff) &&
                     (earlier == '0);
  assign res.mult  = sum;

endmodule

>>> rtl/core/moe_rc_merge.sv
// Merge stage: walks the lanes' first-appearance mask one entry per cycle
// while the read stage is free, keeps the per-expert counts in a memory with
// valid bits, and holds the output register. Depends on moe_rc_pkg.
module moe_rc_merge #(
  parameter int NUM_EXPERTS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             ld_valid,
  input  moe_rc_pkg::tok_load_t            ld_data,
  output logic                             ld_ready,
  input  logic [moe_rc_pkg::CNT_W-1:0]     row_cap,
  input  logic [8:0]                       ne_max,
  output logic                             out_valid,
  input  logic                             out_ready,
  output moe_rc_pkg::out_item_t            out_data
);

  localparam int EW = (NUM_EXPERTS > 1) ? $clog2(NUM_EXPERTS) : 1;

  // Scanner holding the current item.
  logic                                sc_vld_r;
  logic [1:0]                          sc_cmd_r;
  logic [moe_rc_pkg::MAX_TOPK-1:0]     sc_mask_r;
  moe_rc_pkg::id_vec_t                 sc_ids_r;
  moe_rc_pkg::mult_vec_t               sc_mult_r;
  logic [moe_rc_pkg::ROUTE_W-1:0]      sc_base_r;
  logic                                sc_tovf_r;
  logic [moe_rc_pkg::EXP_W-1:0]        sc_query_r;

  logic [moe_rc_pkg::LANE_W-1:0]       pick_idx;
  logic [moe_rc_pkg::MAX_TOPK-1:0]     pick_oh;
  logic [moe_rc_pkg::MAX_TOPK-1:0]     rest;
  logic                                sc_last;
  logic                                iss;
  logic                                ld_fire;
  logic                                ld_keep;
  logic [1:0]                          iss_kind;
  logic [moe_rc_pkg::ID_W-1:0]         iss_id;
  logic                                iss_qok;
  logic [EW-1:0]                       iss_addr;
  logic [moe_rc_pkg::ROUTE_W-1:0]      iss_route;
  logic [moe_rc_pkg::MULT_W-1:0]       iss_mult;

  // Read stage.
  logic                                b_vld_r;
  logic [1:0]                          b_kind_r;
  logic [moe_rc_pkg::ID_W-1:0]         b_id_r;
  logic                                b_qok_r;
  logic [moe_rc_pkg::ROUTE_W-1:0]      b_route_r;
  logic [moe_rc_pkg::MULT_W-1:0]       b_mult_r;
  logic                                b_tovf_r;
  logic                                b_last_r;
  logic [moe_rc_pkg::CNT_W-1:0]        rd_r;
  logic                                rdv_r;
  logic                                fwd_r;
  logic [moe_rc_pkg::CNT_W-1:0]        fwd_val_r;

  logic                                b_adv;
  logic                                b_free;
  logic                                b_wr;
  logic [EW-1:0]                       b_addr;
  logic [moe_rc_pkg::CNT_W-1:0]        cnt_old;
  logic [moe_rc_pkg::CNT_W-1:0]        cnt_new;
  logic [moe_rc_pkg::SLOT_W-1:0]       slot;
  logic                                ovf;
  moe_rc_pkg::out_item_t               res_nxt;

  // Count memory and valid bits.
  logic [moe_rc_pkg::CNT_W-1:0]        cnt_mem [NUM_EXPERTS];
  logic [NUM_EXPERTS-1:0]              vld_r;

  logic                                o_vld_r;
  moe_rc_pkg::out_item_t               o_data_r;

  always_comb begin
    pick_idx = '0;
    for (int i = moe_rc_pkg::MAX_TOPK - 1; i >= 0; i--) begin
      if (sc_mask_r[i]) begin
        pick_idx = moe_rc_pkg::LANE_W'(i);
      end
    end
  end

  assign pick_oh  = moe_rc_pkg::MAX_TOPK'(1) << pick_idx;
  assign rest     = sc_mask_r & ~pick_oh;
  assign sc_last  = (sc_cmd_r != moe_rc_pkg::CMD_ROUTE) || (rest == '0);
  assign b_adv    = b_vld_r && (!o_vld_r || out_ready);
  assign b_free   = !b_vld_r || b_adv;
  assign iss      = sc_vld_r && b_free;
  assign ld_ready = !sc_vld_r || (b_free && sc_last);
  assign ld_fire  = ld_valid && ld_ready;
  assign ld_keep  = ((ld_data.cmd == moe_rc_pkg::CMD_ROUTE) && (ld_data.mask != '0)) ||
                    (ld_data.cmd == moe_rc_pkg::CMD_READ) ||
                    (ld_data.cmd == moe_rc_pkg::CMD_CLEAR);

  always_comb begin
    iss_kind = moe_rc_pkg::KIND_ROUTE;
    iss_id   = sc_ids_r[pick_idx];
    iss_qok  = 1'b1;
    unique case (sc_cmd_r)
      moe_rc_pkg::CMD_ROUTE: begin
        iss_kind = moe_rc_pkg::KIND_ROUTE;
      end
      moe_rc_pkg::CMD_READ: begin
        iss_kind = moe_rc_pkg::KIND_READ;
        iss_id   = {2'b00, sc_query_r};
        iss_qok  = {3'b000, sc_query_r} < ne_max;
      end
      default: begin
        iss_kind = moe_rc_pkg::KIND_CLEAR;
        iss_id   = '0;
      end
    endcase
  end

  assign iss_addr  = iss_id[EW-1:0];
  assign iss_route = sc_base_r + moe_rc_pkg::ROUTE_W'(pick_idx);
  assign iss_mult  = sc_mult_r[pick_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r <= 1'b0;
    end else if (ld_fire) begin
      sc_vld_r <= ld_keep;
    end else if (iss && sc_last) begin
      sc_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_fire) begin
      sc_cmd_r   <= ld_data.cmd;
      sc_mask_r  <= ld_data.mask;
      sc_ids_r   <= ld_data.ids;
      sc_mult_r  <= ld_data.mult;
      sc_base_r  <= ld_data.base;
      sc_tovf_r  <= ld_data.tok_ovf;
      sc_query_r <= ld_data.query;
    end else if (iss) begin
      sc_mask_r  <= rest;
    end
  end

  assign cnt_old = fwd_r ? fwd_val_r : (rdv_r ? rd_r : '0);
  assign slot    = (cnt_old > {1'b0, moe_rc_pkg::SLOT_MAX}) ? moe_rc_pkg::SLOT_MAX :
                   cnt_old[moe_rc_pkg::SLOT_W-1:0];
  assign ovf     = (cnt_old >= row_cap) || b_tovf_r;
  assign cnt_new = (cnt_old < moe_rc_pkg::COUNT_MAX) ? cnt_old + 1'b1 : cnt_old;
  assign b_wr    = b_adv && (b_kind_r == moe_rc_pkg::KIND_ROUTE);
  assign b_addr  = b_id_r[EW-1:0];

  always_comb begin
    res_nxt      = '0;
    res_nxt.kind = b_kind_r;
    res_nxt.last = b_last_r;
    unique case (b_kind_r)
      moe_rc_pkg::KIND_ROUTE: begin
        res_nxt.expert       = b_id_r[moe_rc_pkg::EXP_W-1:0];
        res_nxt.slot         = slot;
        res_nxt.route_index  = b_route_r;
        res_nxt.multiplicity = b_mult_r;
        res_nxt.count        = cnt_new;
        res_nxt.overflow     = ovf;
      end
      moe_rc_pkg::KIND_READ: begin
        res_nxt.expert = b_id_r[moe_rc_pkg::EXP_W-1:0];
        res_nxt.count  = b_qok_r ? cnt_old : '0;
      end
      default: begin
        res_nxt.kind = moe_rc_pkg::KIND_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_free) begin
      b_vld_r <= iss;
    end
  end

  // A write and a read of the same entry at one edge see the old data, so the
  // value leaving the read stage is forwarded; a clear forwards zero.
  always_ff @(posedge clk) begin
    if (iss) begin
      b_kind_r  <= iss_kind;
      b_id_r    <= iss_id;
      b_qok_r   <= iss_qok;
      b_route_r <= iss_route;
      b_mult_r  <= iss_mult;
      b_tovf_r  <= sc_tovf_r;
      b_last_r  <= sc_last;
      rd_r      <= cnt_mem[iss_addr];
      rdv_r     <= vld_r[iss_addr];
      fwd_r     <= b_adv && ((b_kind_r == moe_rc_pkg::KIND_CLEAR) ||
                   ((b_kind_r == moe_rc_pkg::KIND_ROUTE) && (b_id_r == iss_id)));
      fwd_val_r <= (b_kind_r == moe_rc_pkg::KIND_CLEAR) ? '0 : cnt_new;
    end
    if (b_wr) begin
      cnt_mem[b_addr] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (b_adv && (b_kind_r == moe_rc_pkg::KIND_CLEAR)) begin
      vld_r <= '0;
    end else if (b_wr) begin
      vld_r[b_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (b_adv) begin
      o_vld_r <= 1'b1;
    end else if (out_ready) begin
      o_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      o_data_r <= res_nxt;
    end
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_data_r;

endmodule

>>> rtl/core/moe_expert_route_compactor_core.sv
// Top level of the expert route compactor: configuration registers, token
// counter, the eight position lanes and the merge stage.
// Depends on moe_rc_pkg, moe_rc_lane and moe_rc_merge.
//
// Usage: an input item on in_valid/in_ready carries a command. A routing item
// holds up to eight expert ids; the block emits one route entry per distinct
// valid expert, in order of first appearance, with last set on the final one.
// A count read and a clear each give one result item; a routing item with no
// valid id and command three give none. Configuration goes through the APB
// port (top_k at 0x0, num_experts at 0x4, row_capacity at 0x8) while idle.
// An accepted item passes through the scanner register, the read stage and
// the output register. The result channel carries one item per cycle while
// the receiver is ready; the route entries of a token, one per distinct valid
// expert (one to eight), issue in turn through the single read-modify-write
// port of the count memory; an item with no result is dropped. A new item is
// accepted while the previous one's last entry is issued. Reset clears the
// counts (through per-expert valid bits), the token counter and the registers
// to their defaults. When the receiver stalls, the output register holds its
// item and the pipeline behind it fills, then in_ready falls.
module moe_expert_route_compactor_core #(
  parameter int NUM_EXPERTS = 64,
  parameter int MAX_TOKENS  = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  moe_rc_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output moe_rc_pkg::out_item_t out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [3:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int TW = $clog2(MAX_TOKENS + 1);
  localparam int PW = (TW + 4 > moe_rc_pkg::ROUTE_W) ? TW + 4 : moe_rc_pkg::ROUTE_W;
  localparam logic [8:0]    NE_MAX  = 9'(NUM_EXPERTS);
  localparam logic [TW-1:0] TOK_MAX = TW'(MAX_TOKENS);

  logic [moe_rc_pkg::TOPK_W-1:0] top_k_r;
  logic [moe_rc_pkg::NE_W-1:0]   num_experts_r;
  logic [moe_rc_pkg::CNT_W-1:0]  row_cap_r;
  logic [TW-1:0]                 tok_cnt_r;
  logic                          cfg_wr;
  logic                          in_fire;

  logic [moe_rc_pkg::TOPK_W-1:0] k_eff;
  logic [8:0]                    ne_eff;
  logic [PW-1:0]                 prod;
  moe_rc_pkg::id_vec_t           ids;
  moe_rc_pkg::lane_res_t         lane_res [moe_rc_pkg::MAX_TOPK];
  moe_rc_pkg::tok_load_t         ld;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_k_r       <= 4'd8;
      num_experts_r <= 7'd64;
      row_cap_r     <= 13'd4096;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        moe_rc_pkg::REG_TOP_K:        top_k_r       <= cfg_pwdata[moe_rc_pkg::TOPK_W-1:0];
        moe_rc_pkg::REG_NUM_EXPERTS:  num_experts_r <= cfg_pwdata[moe_rc_pkg::NE_W-1:0];
        moe_rc_pkg::REG_ROW_CAPACITY: row_cap_r     <= cfg_pwdata[moe_rc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      moe_rc_pkg::REG_TOP_K:        cfg_prdata = {28'd0, top_k_r};
      moe_rc_pkg::REG_NUM_EXPERTS:  cfg_prdata = {25'd0, num_experts_r};
      moe_rc_pkg::REG_ROW_CAPACITY: cfg_prdata = {19'd0, row_cap_r};
      default:                      cfg_prdata = '0;
    endcase
  end

  assign k_eff  = (top_k_r > 4'd8) ? 4'd8 : top_k_r;
  assign ne_eff = ({2'b00, num_experts_r} > NE_MAX) ? NE_MAX : {2'b00, num_experts_r};

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_cnt_r <= '0;
    end else if (in_fire && (in_data.cmd == moe_rc_pkg::CMD_CLEAR)) begin
      tok_cnt_r <= '0;
    end else if (in_fire && (in_data.cmd == moe_rc_pkg::CMD_ROUTE) &&
                 (tok_cnt_r < TOK_MAX)) begin
      tok_cnt_r <= tok_cnt_r + 1'b1;
    end
  end

  assign prod = PW'(tok_cnt_r) * PW'(k_eff);

  assign ids[0] = in_data.expert_id_0;
  assign ids[1] = in_data.expert_id_1;
  assign ids[2] = in_data.expert_id_2;
  assign ids[3] = in_data.expert_id_3;
  assign ids[4] = in_data.expert_id_4;
  assign ids[5] = in_data.expert_id_5;
  assign ids[6] = in_data.expert_id_6;
  assign ids[7] = in_data.expert_id_7;

  for (genvar p = 0; p < moe_rc_pkg::MAX_TOPK; p++) begin : g_lane
    moe_rc_lane u_lane (
      .ids     (ids),
      .own_pos (moe_rc_pkg::LANE_W'(p)),
      .k_eff   (k_eff),
      .ne_eff  (ne_eff),
      .res     (lane_res[p])
    );
    assign ld.mask[p] = lane_res[p].first;
    assign ld.mult[p] = lane_res[p].mult;
  end

  assign ld.cmd     = in_data.cmd;
  assign ld.ids     = ids;
  assign ld.base    = prod[moe_rc_pkg::ROUTE_W-1:0];
  assign ld.tok_ovf = (tok_cnt_r >= TOK_MAX);
  assign ld.query   = in_data.query_expert;

  moe_rc_merge #(
    .NUM_EXPERTS (NUM_EXPERTS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_valid  (in_valid),
    .ld_data   (ld),
    .ld_ready  (in_ready),
    .row_cap   (row_cap_r),
    .ne_max    (NE_MAX),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/moe_rc_checker.sv
// Port-level checker for the expert route compactor, attached to the top level
// by the bind statement at the end of this file. Depends on moe_rc_pkg.
module moe_rc_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input moe_rc_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result item changed or dropped while stalled.");

  a_route_mult: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == moe_rc_pkg::KIND_ROUTE) |->
      (out_data.multiplicity != 4'd0) && (out_data.multiplicity <= 4'd8))
    else $error("Route entry with impossible multiplicity.");

  a_route_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == moe_rc_pkg::KIND_ROUTE) &&
      (out_data.slot != moe_rc_pkg::SLOT_MAX) |->
      (out_data.count == {1'b0, out_data.slot} + 13'd1))
    else $error("Route entry count does not follow its slot.");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.kind == moe_rc_pkg::KIND_READ) ||
      (out_data.kind == moe_rc_pkg::KIND_CLEAR)) |-> out_data.last)
    else $error("Count reply or clear acknowledge without last.");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == moe_rc_pkg::KIND_CLEAR) |->
      (out_data.count == '0) && (out_data.expert == '0) && !out_data.overflow)
    else $error("Clear acknowledge carries nonzero fields.");

endmodule

bind moe_expert_route_compactor_core moe_rc_checker u_moe_rc_checker (.*);

>>> sim/moe_expert_route_compactor_core_tb.sv
// Self-checking testbench for moe_expert_route_compactor_core: directed and random
// routing, count-read and clear items checked against an in-bench route predictor.
// Depends on moe_rc_pkg and the core RTL.
`timescale 1ns / 100ps

class route_scoreboard #(int EXPERTS = 64, int TOKEN_LIMIT = 4096);
  logic [12:0] expert_count [EXPERTS];
  int unsigned token_num;
  logic [3:0]  top_k;
  logic [6:0]  num_experts;
  logic [12:0] row_capacity;
  moe_rc_pkg::out_item_t owed[$];
  int unsigned errors;

  function new();
    foreach (expert_count[e]) expert_count[e] = '0;
    token_num = 0;
    top_k = 4'd8;
    num_experts = 7'd64;
    row_capacity = 13'd4096;
    errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      moe_rc_pkg::REG_TOP_K:        top_k = val[3:0];
      moe_rc_pkg::REG_NUM_EXPERTS:  num_experts = val[6:0];
      moe_rc_pkg::REG_ROW_CAPACITY: row_capacity = val[12:0];
      default: ;
    endcase
  endfunction

  function int unsigned valid_experts();
    return (num_experts > EXPERTS) ? EXPERTS : num_experts;
  endfunction

  function void predict(moe_rc_pkg::in_item_t it);
    moe_rc_pkg::out_item_t res [8];
    logic [7:0] ids [8];
    bit done [8];
    int unsigned k, ne, n, cnt, mult;
    ids[0] = it.expert_id_0;
    ids[1] = it.expert_id_1;
    ids[2] = it.expert_id_2;
    ids[3] = it.expert_id_3;
    ids[4] = it.expert_id_4;
    ids[5] = it.expert_id_5;
    ids[6] = it.expert_id_6;
    ids[7] = it.expert_id_7;
    case (it.cmd)
      moe_rc_pkg::CMD_ROUTE: begin
        k = (top_k > moe_rc_pkg::MAX_TOPK) ? moe_rc_pkg::MAX_TOPK : top_k;
        ne = valid_experts();
        n = 0;
        foreach (done[i]) done[i] = 1'b0;
        for (int p = 0; p < k; p++) begin
          if (!done[p] && ids[p] < ne) begin
            mult = 0;
            for (int q = p; q < k; q++) begin
              if (ids[q] == ids[p]) begin
                mult++;
                done[q] = 1'b1;
              end
            end
            cnt = expert_count[ids[p]];
            res[n] = '0;
            res[n].kind = moe_rc_pkg::KIND_ROUTE;
            res[n].expert = ids[p][5:0];
            res[n].slot = (cnt > moe_rc_pkg::SLOT_MAX) ? moe_rc_pkg::SLOT_MAX : 12'(cnt);
            res[n].route_index = 15'(token_num * k + p);
            res[n].multiplicity = 4'(mult);
            res[n].overflow = (cnt >= row_capacity) || (token_num >= TOKEN_LIMIT);
            if (cnt < moe_rc_pkg::COUNT_MAX) cnt++;
            expert_count[ids[p]] = 13'(cnt);
            res[n].count = 13'(cnt);
            n++;
          end
        end
        for (int i = 0; i < n; i++) begin
          res[i].last = (i == n - 1);
          owed.push_back(res[i]);
        end
        if (token_num < TOKEN_LIMIT) token_num++;
      end
      moe_rc_pkg::CMD_READ: begin
        res[0] = '0;
        res[0].kind = moe_rc_pkg::KIND_READ;
        res[0].expert = it.query_expert;
        res[0].count = (it.query_expert < EXPERTS) ? expert_count[it.query_expert] : '0;
        res[0].last = 1'b1;
        owed.push_back(res[0]);
      end
      moe_rc_pkg::CMD_CLEAR: begin
        foreach (expert_count[e]) expert_count[e] = '0;
        token_num = 0;
        res[0] = '0;
        res[0].kind = moe_rc_pkg::KIND_CLEAR;
        res[0].last = 1'b1;
        owed.push_back(res[0]);
      end
      default: ;
    endcase
  endfunction

  function string fields(moe_rc_pkg::out_item_t r);
    return $sformatf("kind %0d expert %0d slot %0d route %0d mult %0d count %0d ovf %0d last %0d",
                     r.kind, r.expert, r.slot, r.route_index, r.multiplicity, r.count,
                     r.overflow, r.last);
  endfunction

  function void report(string what, moe_rc_pkg::out_item_t want, moe_rc_pkg::out_item_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t %s", $time, what);
      $display("  expected: %s", fields(want));
      $display("  actual:   %s", fields(got));
    end
  endfunction

  function void check(moe_rc_pkg::out_item_t got);
    moe_rc_pkg::out_item_t want;
    if (owed.size() == 0) begin
      report("result item with nothing expected", '0, got);
    end else begin
      want = owed.pop_front();
      if (got.kind !== want.kind || got.expert !== want.expert || got.slot !== want.slot ||
          got.route_index !== want.route_index || got.multiplicity !== want.multiplicity ||
          got.count !== want.count || got.overflow !== want.overflow ||
          got.last !== want.last)
        report("result item mismatch", want, got);
    end
  endfunction

  function void finish_check();
    while (owed.size() != 0) report("expected result item never seen", owed.pop_front(), '0);
  endfunction
endclass

module moe_expert_route_compactor_core_tb;

  localparam int EXPERTS       = 64;
  localparam int TOKEN_LIMIT   = 4096;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOT_TOKENS    = 16;
  localparam logic [7:0] HOT_EXPERT  = 8'd5;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  moe_rc_pkg::in_item_t  in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  moe_rc_pkg::out_item_t out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [3:0]            cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  int unsigned stall_cycles = 0;
  route_scoreboard #(EXPERTS, TOKEN_LIMIT) sb;

  always #5 clk = ~clk;

  moe_expert_route_compactor_core #(
    .NUM_EXPERTS(EXPERTS),
    .MAX_TOKENS (TOKEN_LIMIT)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always @(posedge clk) out_ready <= ($urandom_range(99) >= out_idle_pct);

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.predict(in_data);
      if (out_valid && out_ready) sb.check(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles++;
      end
    end
  end

  function automatic moe_rc_pkg::in_item_t route(input logic [7:0] e0, e1, e2, e3,
                                                 e4, e5, e6, e7);
    moe_rc_pkg::in_item_t it;
    it.cmd = moe_rc_pkg::CMD_ROUTE;
    it.expert_id_0 = e0;
    it.expert_id_1 = e1;
    it.expert_id_2 = e2;
    it.expert_id_3 = e3;
    it.expert_id_4 = e4;
    it.expert_id_5 = e5;
    it.expert_id_6 = e6;
    it.expert_id_7 = e7;
    it.query_expert = 6'($urandom_range(63));
    return it;
  endfunction

  function automatic moe_rc_pkg::in_item_t command(input logic [1:0] cmd,
                                                   input logic [5:0] query);
    moe_rc_pkg::in_item_t it;
    it = route(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    it.cmd = cmd;
    it.query_expert = query;
    return it;
  endfunction

  function automatic moe_rc_pkg::in_item_t random_item();
    logic [7:0] ids [8];
    int unsigned ne, pool, base, sel;
    moe_rc_pkg::in_item_t it;
    ne = sb.valid_experts();
    pool = (ne == 0) ? 1 : $urandom_range(ne, 1);
    base = (ne > pool) ? $urandom_range(ne - pool) : 0;
    foreach (ids[i])
      ids[i] = (ne == 0 || $urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                   : 8'(base + $urandom_range(pool - 1));
    it = route(ids[0], ids[1], ids[2], ids[3], ids[4], ids[5], ids[6], ids[7]);
    sel = $urandom_range(99);
    if (sel < 6) it.cmd = moe_rc_pkg::CMD_READ;
    else if (sel < 9) it.cmd = moe_rc_pkg::CMD_CLEAR;
    else if (sel < 11) it.cmd = CMD_IGNORED;
    return it;
  endfunction

  function automatic moe_rc_pkg::in_item_t hot_item();
    logic [7:0] ids [8];
    logic [7:0] mask;
    mask = 8'($urandom_range(255, 1));
    foreach (ids[i]) ids[i] = mask[i] ? HOT_EXPERT : 8'($urandom_range(255, 64));
    return route(ids[0], ids[1], ids[2], ids[3], ids[4], ids[5], ids[6], ids[7]);
  endfunction

  task automatic send_item(input moe_rc_pkg::in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, val);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_config(input int unsigned k, input int unsigned ne, input int unsigned cap);
    drain();
    write_reg(moe_rc_pkg::REG_TOP_K, 32'(k));
    write_reg(moe_rc_pkg::REG_NUM_EXPERTS, 32'(ne));
    write_reg(moe_rc_pkg::REG_ROW_CAPACITY, 32'(cap));
  endtask

  task automatic random_config();
    int unsigned k, ne, cap;
    case ($urandom_range(3))
      0: k = 1;
      1: k = 8;
      2: k = $urandom_range(15);
      default: k = $urandom_range(8, 1);
    endcase
    case ($urandom_range(3))
      0: ne = 1;
      1: ne = 64;
      2: ne = $urandom_range(127);
      default: ne = $urandom_range(12, 2);
    endcase
    case ($urandom_range(3))
      0: cap = $urandom_range(3);
      1: cap = 4096;
      2: cap = 8191;
      default: cap = $urandom_range(24, 1);
    endcase
    set_config(k, ne, cap);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_item(route(8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd63));
    send_item(route(8'd63, 8'd63, 8'd63, 8'd63, 8'd63, 8'd63, 8'd63, 8'd63));
    send_item(route(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    send_item(route(8'd64, 8'd0, 8'd64, 8'd0, 8'd200, 8'd1, 8'd1, 8'd0));
    send_item(command(moe_rc_pkg::CMD_READ, 6'd63));
    send_item(command(moe_rc_pkg::CMD_READ, 6'd7));
    send_item(command(CMD_IGNORED, 6'd63));
    send_item(command(moe_rc_pkg::CMD_CLEAR, 6'd0));
    send_item(command(moe_rc_pkg::CMD_READ, 6'd0));

    set_config(0, 64, 4096);
    send_item(route(8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7));
    set_config(15, 127, 0);
    send_item(route(8'd100, 8'd64, 8'd3, 8'd3, 8'd127, 8'd63, 8'd0, 8'd0));
    send_item(route(8'd3, 8'd42, 8'd42, 8'd42, 8'd42, 8'd42, 8'd42, 8'd3));
    set_config(1, 0, 8191);
    send_item(route(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    set_config(1, 1, 1);
    send_item(route(8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7));
    send_item(route(8'd0, 8'd0, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9));
    send_item(command(moe_rc_pkg::CMD_READ, 6'd0));
    set_config(3, 8, 2);
    send_item(route(8'd7, 8'd7, 8'd6, 8'd8, 8'd7, 8'd6, 8'd6, 8'd6));
    send_item(route(8'd7, 8'd6, 8'd7, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_item(route(8'd6, 8'd6, 8'd6, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1));

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      in_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 78 : 0;
      out_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 24 : 0;
      for (int sub = 0; sub < 3; sub++) begin
        random_config();
        repeat (36) send_item(random_item());
      end
    end

    // A short run on one expert repeats it at random positions among
    // invalid ids, then reads its count back.
    set_config(8, 64, 4096);
    send_item(command(moe_rc_pkg::CMD_CLEAR, 6'd0));
    repeat (HOT_TOKENS) send_item(hot_item());
    send_item(command(moe_rc_pkg::CMD_READ, HOT_EXPERT[5:0]));
    send_item(random_item());

    drain();
    sb.finish_check();
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
